@@ sv/bct_pkg.sv @@
// shared constants for the blob centroid tracker
// register indexes, item codes and reset values; no dependencies

package bct_pkg;

    localparam int TRACKED_SLOTS_DEF   = 16;
    localparam int CANDIDATE_SLOTS_DEF = 16;
    localparam int COORD_BITS_DEF      = 12;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int ID_BITS       = 16;
    localparam int TIME_BITS     = 32;
    localparam int WEIGHT_BITS   = 9;
    localparam int DIST_CFG_BITS = 12;
    localparam int MS_CFG_BITS   = 16;

    localparam logic [WEIGHT_BITS-1:0] Q8_ONE = 9'd256;
    localparam logic [ID_BITS-1:0]     ID_PENDING_OUT = 16'hFFFF;

    localparam logic [DIST_CFG_BITS-1:0] MERGE_DIST_RST = 12'd100;
    localparam logic [WEIGHT_BITS-1:0]   SMOOTH_RST     = 9'd256;
    localparam logic [MS_CFG_BITS-1:0]   MIN_DET_RST    = 16'd500;
    localparam logic [MS_CFG_BITS-1:0]   MAX_UNDET_RST  = 16'd500;
    localparam logic [ID_BITS-1:0]       MAX_ID_RST     = 16'd9999;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_MERGE_DIST  = 3'd0,
        CFG_SMOOTH      = 3'd1,
        CFG_CAND_EN     = 3'd2,
        CFG_MIN_DET     = 3'd3,
        CFG_TIMEOUT_EN  = 3'd4,
        CFG_MAX_UNDET   = 3'd5,
        CFG_LOWEST_ID   = 3'd6,
        CFG_MAX_ID      = 3'd7
    } t_cfg_addr;

    typedef enum logic {
        OP_DETECT    = 1'b0,
        OP_FRAME_END = 1'b1
    } t_op;

endpackage

@@ sv/blob_centroid_tracker.sv @@
// blob centroid tracker top level: control sequencer over two table memories
// uses bct_pkg, bct_ram, bct_dist and bct_blend
//
// input channel i_valid / o_stall carries either a detection (operation 0,
// pos_x, pos_y, time_ms) or a frame end (operation 1, time_ms). output channel
// o_valid / i_stall carries tracked blobs after a frame end, in table order,
// with o_last on the final one; an empty table gives one item with present 0.
// items are taken one at a time; o_stall is high while one is in work.
// a detection scans the tracked table and, when it misses and the candidate
// filter is on, then the candidate table; each scan reads one entry per cycle
// through the memory read port into a two-stage distance unit. a matched
// tracked update reads, blends and writes the entry; a matched candidate
// update reads and writes it.
// a frame end sweeps the candidate table when the candidate filter is on,
// the tracked table for timeouts and, in lowest id mode, the tracked table
// for id assignment, then emits the results while the receiver takes them.
// a stalled result holds in the output register; the next item is accepted
// while the final result of a frame end still waits there.
// reset clears the fill counts, the sequential id and the configuration;
// the memories need no clearing since only filled entries are read.

module blob_centroid_tracker #(
    parameter int TRACKED_SLOTS   = bct_pkg::TRACKED_SLOTS_DEF,
    parameter int CANDIDATE_SLOTS = bct_pkg::CANDIDATE_SLOTS_DEF,
    parameter int COORD_BITS      = bct_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_operation,
    input  logic [COORD_BITS-1:0]             i_pos_x,
    input  logic [COORD_BITS-1:0]             i_pos_y,
    input  logic [bct_pkg::TIME_BITS-1:0]     i_time_ms,
    input  logic                              i_cfg_we,
    input  logic [bct_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [bct_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bct_pkg::ID_BITS-1:0]       o_blob_id,
    output logic [COORD_BITS-1:0]             o_blob_x,
    output logic [COORD_BITS-1:0]             o_blob_y,
    output logic                              o_present,
    output logic                              o_last
);

    import bct_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int MAXS = (TRACKED_SLOTS > CANDIDATE_SLOTS) ? TRACKED_SLOTS : CANDIDATE_SLOTS;
    localparam int KW   = $clog2(MAXS + 1);
    localparam int TIW  = (TRACKED_SLOTS > 1) ? $clog2(TRACKED_SLOTS) : 1;
    localparam int CIW  = (CANDIDATE_SLOTS > 1) ? $clog2(CANDIDATE_SLOTS) : 1;
    localparam int LW   = $clog2(TRACKED_SLOTS + 1);
    localparam int DW   = (2 * C + 1 > 2 * DIST_CFG_BITS) ? 2 * C + 1 : 2 * DIST_CFG_BITS;
    localparam int TWW  = 2 * C + ID_BITS + 1 + TIME_BITS;
    localparam int CWW  = 2 * C + 2 * TIME_BITS;
    localparam int T_ID = 2 * C;
    localparam int T_PD = 2 * C + ID_BITS;
    localparam int T_SN = 2 * C + ID_BITS + 1;
    localparam int C_FS = 2 * C;
    localparam int C_SN = 2 * C + TIME_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TSCAN,
        S_TUPD_RD,
        S_TUPD_WAIT,
        S_TUPD_WR,
        S_CSCAN,
        S_CUPD_RD,
        S_CUPD_WR,
        S_FCAND,
        S_FTRK,
        S_FID,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;

    logic [DIST_CFG_BITS-1:0] r_md;
    logic [WEIGHT_BITS-1:0]   r_sw;
    logic                     r_cfe, r_toe, r_lidm;
    logic [MS_CFG_BITS-1:0]   r_mind, r_maxu, r_maxid;

    logic [C-1:0]         r_x, r_y;
    logic [TIME_BITS-1:0] r_t;
    logic [KW-1:0]        r_tcnt, r_ccnt;
    logic [ID_BITS-1:0]   r_seq;
    logic [KW-1:0]        r_rd, r_wr, r_recv, r_pidx, r_best;
    logic                 r_pv, r_found;
    logic [DW-1:0]        r_bestd, r_lim;
    logic [TRACKED_SLOTS:0] r_mask;

    logic               r_ovalid, r_opres, r_olast;
    logic [ID_BITS-1:0] r_oid;
    logic [C-1:0]       r_ox, r_oy;

    logic             t_we, c_we;
    logic [TIW-1:0]   t_waddr, t_raddr;
    logic [CIW-1:0]   c_waddr, c_raddr;
    logic [TWW-1:0]   t_wdata, t_q;
    logic [CWW-1:0]   c_wdata, c_q;

    logic [C-1:0]         tq_x, tq_y, cq_x, cq_y, dist_ax, dist_ay, bl_x, bl_y;
    logic [ID_BITS-1:0]   tq_id;
    logic                 tq_pend;
    logic [TIME_BITS-1:0] tq_seen, cq_first, cq_seen, maxu32;

    logic          d_valid;
    logic [KW-1:0] d_idx;
    logic [DW-1:0] d_dist;

    logic          in_acc, out_free, scan_done, sweep_done, ld_out;
    logic          t_room, c_room, c_stale, c_mature, t_stale, id_over, d_better;
    logic [KW-1:0] scan_cnt;
    logic [LW-1:0] free_id;
    logic [2*DIST_CFG_BITS-1:0] md_sq;

    function automatic logic [LW-1:0] lowest_free(input logic [TRACKED_SLOTS:0] mask);
        logic [LW-1:0] res;
        res = '0;
        for (int i = TRACKED_SLOTS; i >= 0; i--) begin
            if (!mask[i]) begin
                res = LW'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [TWW-1:0] new_trk(input logic [C-1:0] x, input logic [C-1:0] y,
                                               input logic [TIME_BITS-1:0] seen,
                                               input logic lidm, input logic [ID_BITS-1:0] seq);
        return {seen, lidm, (lidm ? {ID_BITS{1'b0}} : seq), y, x};
    endfunction

    assign tq_x     = t_q[C-1:0];
    assign tq_y     = t_q[2*C-1:C];
    assign tq_id    = t_q[T_PD-1:T_ID];
    assign tq_pend  = t_q[T_PD];
    assign tq_seen  = t_q[TWW-1:T_SN];
    assign cq_x     = c_q[C-1:0];
    assign cq_y     = c_q[2*C-1:C];
    assign cq_first = c_q[C_SN-1:C_FS];
    assign cq_seen  = c_q[CWW-1:C_SN];

    assign maxu32   = r_toe ? TIME_BITS'(r_maxu) : '0;
    assign c_stale  = (r_t - cq_seen) > maxu32;
    assign c_mature = (cq_seen - cq_first) > TIME_BITS'(r_mind);
    assign t_stale  = (r_t - tq_seen) > maxu32;
    assign free_id  = lowest_free(r_mask);
    assign id_over  = ID_BITS'(free_id) > r_maxid;
    assign t_room   = r_tcnt < KW'(TRACKED_SLOTS);
    assign c_room   = r_ccnt < KW'(CANDIDATE_SLOTS);
    assign md_sq    = (2*DIST_CFG_BITS)'(r_md) * (2*DIST_CFG_BITS)'(r_md);

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign ld_out   = out_free && ((r_state == S_EMIT_RD && r_tcnt == '0) ||
                                   r_state == S_EMIT_LD);
    assign scan_cnt = (r_state == S_CSCAN) ? r_ccnt : r_tcnt;
    assign scan_done = (r_recv == scan_cnt);
    assign sweep_done = !r_pv && (r_rd >= ((r_state == S_FCAND) ? r_ccnt : r_tcnt));
    assign d_better = (d_dist < r_lim) && (!r_found || d_dist < r_bestd);

    assign dist_ax = (r_state == S_CSCAN) ? cq_x : tq_x;
    assign dist_ay = (r_state == S_CSCAN) ? cq_y : tq_y;

    assign t_raddr = (r_state == S_TUPD_RD || r_state == S_TUPD_WAIT || r_state == S_TUPD_WR)
                     ? r_best[TIW-1:0] : r_rd[TIW-1:0];
    assign c_raddr = (r_state == S_CUPD_RD || r_state == S_CUPD_WR)
                     ? r_best[CIW-1:0] : r_rd[CIW-1:0];

    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_wr[TIW-1:0];
        t_wdata = t_q;
        c_we    = 1'b0;
        c_waddr = r_wr[CIW-1:0];
        c_wdata = c_q;
        case (r_state)
            S_TSCAN: begin
                if (scan_done && !r_found && !r_cfe && t_room) begin
                    t_we    = 1'b1;
                    t_waddr = r_tcnt[TIW-1:0];
                    t_wdata = new_trk(r_x, r_y, r_t, r_lidm, r_seq);
                end
            end
            S_TUPD_WR: begin
                t_we    = 1'b1;
                t_waddr = r_best[TIW-1:0];
                t_wdata = {r_t, tq_pend, tq_id, bl_y, bl_x};
            end
            S_CSCAN: begin
                if (scan_done && !r_found && c_room) begin
                    c_we    = 1'b1;
                    c_waddr = r_ccnt[CIW-1:0];
                    c_wdata = {r_t, r_t, r_y, r_x};
                end
            end
            S_CUPD_WR: begin
                c_we    = 1'b1;
                c_waddr = r_best[CIW-1:0];
                c_wdata = {r_t, cq_first, r_y, r_x};
            end
            S_FCAND: begin
                if (r_pv && !c_stale) begin
                    if (c_mature) begin
                        t_we    = t_room;
                        t_waddr = r_tcnt[TIW-1:0];
                        t_wdata = new_trk(cq_x, cq_y, cq_seen, r_lidm, r_seq);
                    end else begin
                        c_we = 1'b1;
                    end
                end
            end
            S_FTRK: begin
                t_we = r_pv && !t_stale;
            end
            S_FID: begin
                if (r_pv) begin
                    if (tq_pend) begin
                        t_we    = !id_over;
                        t_wdata = {tq_seen, 1'b0, ID_BITS'(free_id), tq_y, tq_x};
                    end else begin
                        t_we = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_md     <= MERGE_DIST_RST;
            r_sw     <= SMOOTH_RST;
            r_cfe    <= 1'b1;
            r_mind   <= MIN_DET_RST;
            r_toe    <= 1'b1;
            r_maxu   <= MAX_UNDET_RST;
            r_lidm   <= 1'b0;
            r_maxid  <= MAX_ID_RST;
            r_tcnt   <= '0;
            r_ccnt   <= '0;
            r_seq    <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_MERGE_DIST: r_md    <= i_cfg_wdata[DIST_CFG_BITS-1:0];
                    CFG_SMOOTH:     r_sw    <= i_cfg_wdata[WEIGHT_BITS-1:0];
                    CFG_CAND_EN:    r_cfe   <= i_cfg_wdata[0];
                    CFG_MIN_DET:    r_mind  <= i_cfg_wdata;
                    CFG_TIMEOUT_EN: r_toe   <= i_cfg_wdata[0];
                    CFG_MAX_UNDET:  r_maxu  <= i_cfg_wdata;
                    CFG_LOWEST_ID:  r_lidm  <= i_cfg_wdata[0];
                    CFG_MAX_ID:     r_maxid <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x     <= i_pos_x;
                        r_y     <= i_pos_y;
                        r_t     <= i_time_ms;
                        r_lim   <= DW'(md_sq);
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_recv  <= '0;
                        r_found <= 1'b0;
                        if (t_op'(i_operation) == OP_DETECT) begin
                            r_state <= S_TSCAN;
                        end else if (r_cfe) begin
                            r_state <= S_FCAND;
                        end else begin
                            r_mask  <= '0;
                            r_state <= S_FTRK;
                        end
                    end
                end
                S_TSCAN, S_CSCAN: begin
                    if (r_rd < scan_cnt) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_rd;
                        r_rd   <= r_rd + 1'b1;
                    end else begin
                        r_pv   <= 1'b0;
                    end
                    if (d_valid) begin
                        r_recv <= r_recv + 1'b1;
                        if (d_better) begin
                            r_found <= 1'b1;
                            r_best  <= d_idx;
                            r_bestd <= d_dist;
                        end
                    end
                    if (scan_done) begin
                        if (r_found) begin
                            r_state <= (r_state == S_TSCAN) ? S_TUPD_RD : S_CUPD_RD;
                        end else if (r_state == S_TSCAN && r_cfe) begin
                            r_rd    <= '0;
                            r_recv  <= '0;
                            r_state <= S_CSCAN;
                        end else if (r_state == S_TSCAN) begin
                            if (t_room) begin
                                r_tcnt <= r_tcnt + 1'b1;
                                if (!r_lidm) begin
                                    r_seq <= r_seq + 1'b1;
                                end
                            end
                            r_state <= S_IDLE;
                        end else begin
                            if (c_room) begin
                                r_ccnt <= r_ccnt + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_TUPD_RD:   r_state <= S_TUPD_WAIT;
                S_TUPD_WAIT: r_state <= S_TUPD_WR;
                S_TUPD_WR:   r_state <= S_IDLE;
                S_CUPD_RD:   r_state <= S_CUPD_WR;
                S_CUPD_WR:   r_state <= S_IDLE;
                S_FCAND: begin
                    if (r_rd < r_ccnt) begin
                        r_pv <= 1'b1;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && !c_stale) begin
                        if (c_mature) begin
                            if (t_room) begin
                                r_tcnt <= r_tcnt + 1'b1;
                                if (!r_lidm) begin
                                    r_seq <= r_seq + 1'b1;
                                end
                            end
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end
                    if (sweep_done) begin
                        r_ccnt  <= r_wr;
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_mask  <= '0;
                        r_state <= S_FTRK;
                    end
                end
                S_FTRK: begin
                    if (r_rd < r_tcnt) begin
                        r_pv <= 1'b1;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && !t_stale) begin
                        r_wr <= r_wr + 1'b1;
                        if (!tq_pend && tq_id <= ID_BITS'(TRACKED_SLOTS)) begin
                            r_mask[tq_id[LW-1:0]] <= 1'b1;
                        end
                    end
                    if (sweep_done) begin
                        r_tcnt  <= r_wr;
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_state <= r_lidm ? S_FID : S_EMIT_RD;
                    end
                end
                S_FID: begin
                    if (r_rd < r_tcnt) begin
                        r_pv <= 1'b1;
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (!tq_pend) begin
                            r_wr <= r_wr + 1'b1;
                        end else if (!id_over) begin
                            r_wr <= r_wr + 1'b1;
                            r_mask[free_id] <= 1'b1;
                        end
                    end
                    if (sweep_done) begin
                        r_tcnt  <= r_wr;
                        r_rd    <= '0;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    if (r_tcnt == '0) begin
                        if (out_free) begin
                            r_oid    <= '0;
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_opres  <= 1'b0;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_EMIT_LD;
                    end
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_oid    <= tq_pend ? ID_PENDING_OUT : tq_id;
                        r_ox     <= tq_x;
                        r_oy     <= tq_y;
                        r_opres  <= 1'b1;
                        r_olast  <= (r_rd + 1'b1 == r_tcnt);
                        if (r_rd + 1'b1 == r_tcnt) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd    <= r_rd + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bct_ram #(
        .WIDTH (TWW),
        .DEPTH (TRACKED_SLOTS)
    ) u_trk_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_q)
    );

    bct_ram #(
        .WIDTH (CWW),
        .DEPTH (CANDIDATE_SLOTS)
    ) u_cand_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_q)
    );

    bct_dist #(
        .COORD_BITS (C),
        .IDXW       (KW),
        .DW         (DW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv && (r_state == S_TSCAN || r_state == S_CSCAN)),
        .i_idx   (r_pidx),
        .i_ax    (dist_ax),
        .i_ay    (dist_ay),
        .i_bx    (r_x),
        .i_by    (r_y),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    bct_blend #(
        .COORD_BITS (C)
    ) u_blend (
        .i_clk    (i_clk),
        .i_en     (r_state == S_TUPD_WAIT),
        .i_old_x  (tq_x),
        .i_old_y  (tq_y),
        .i_new_x  (r_x),
        .i_new_y  (r_y),
        .i_weight (r_sw),
        .o_x      (bl_x),
        .o_y      (bl_y)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_blob_id = r_oid;
    assign o_blob_x  = r_ox;
    assign o_blob_y  = r_oy;
    assign o_present = r_opres;
    assign o_last    = r_olast;

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= KW'(TRACKED_SLOTS) && r_ccnt <= KW'(CANDIDATE_SLOTS))
        else $error("table fill count beyond depth");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCAND || r_state == S_FTRK || r_state == S_FID) |-> r_wr <= r_rd)
        else $error("compaction write passed the read pointer");

    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && (r_state == S_TSCAN || r_state == S_CSCAN)) |-> r_bestd < r_lim)
        else $error("match kept outside merge distance");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LD && r_ovalid && i_stall) |=> $stable(r_rd))
        else $error("emit advanced while output blocked");

endmodule

@@ sv/bct_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies

module bct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bct_dist.sv @@
// two-stage squared distance unit: absolute differences, then sum of squares
// no package dependencies

module bct_dist #(
    parameter int COORD_BITS = 12,
    parameter int IDXW       = 5,
    parameter int DW         = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IDXW-1:0]       i_idx,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    input  logic [COORD_BITS-1:0] i_bx,
    input  logic [COORD_BITS-1:0] i_by,
    output logic                  o_valid,
    output logic [IDXW-1:0]       o_idx,
    output logic [DW-1:0]         o_dist
);

    localparam int SQW = 2 * COORD_BITS;

    logic                  r_v1, r_v2;
    logic [IDXW-1:0]       r_i1, r_i2;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [DW-1:0]         r_d;
    logic [COORD_BITS-1:0] n_dx, n_dy;
    logic [SQW-1:0]        sq_x, sq_y;

    assign n_dx = (i_ax >= i_bx) ? (i_ax - i_bx) : (i_bx - i_ax);
    assign n_dy = (i_ay >= i_by) ? (i_ay - i_by) : (i_by - i_ay);
    assign sq_x = SQW'(r_dx) * SQW'(r_dx);
    assign sq_y = SQW'(r_dy) * SQW'(r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_i1 <= i_idx;
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_i2 <= r_i1;
        r_d  <= DW'(sq_x) + DW'(sq_y);
    end

    assign o_valid = r_v2;
    assign o_idx   = r_i2;
    assign o_dist  = r_d;

endmodule

@@ sv/bct_blend.sv @@
// registered q8 blend of a stored position toward a detection
// uses bct_pkg for the q8 unit weight

module bct_blend #(
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [COORD_BITS-1:0]          i_old_x,
    input  logic [COORD_BITS-1:0]          i_old_y,
    input  logic [COORD_BITS-1:0]          i_new_x,
    input  logic [COORD_BITS-1:0]          i_new_y,
    input  logic [bct_pkg::WEIGHT_BITS-1:0] i_weight,
    output logic [COORD_BITS-1:0]          o_x,
    output logic [COORD_BITS-1:0]          o_y
);

    import bct_pkg::*;

    localparam int PW = COORD_BITS + WEIGHT_BITS;

    logic [WEIGHT_BITS-1:0] w, wi;
    logic [PW-1:0]          sum_x, sum_y;
    logic [COORD_BITS-1:0]  r_x, r_y;

    assign w  = (i_weight > Q8_ONE) ? Q8_ONE : i_weight;
    assign wi = Q8_ONE - w;
    assign sum_x = PW'(i_old_x) * PW'(wi) + PW'(i_new_x) * PW'(w);
    assign sum_y = PW'(i_old_y) * PW'(wi) + PW'(i_new_y) * PW'(w);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= sum_x[COORD_BITS+7:8];
            r_y <= sum_y[COORD_BITS+7:8];
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

@@ test/tb.sv @@
// self-checking testbench for blob_centroid_tracker: directed table, then random frames
// predicts tracked blob lists at each frame end; depends on bct_pkg and the tracker rtl
`timescale 1ns / 1ps

module tb;
    import bct_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 120;

    typedef struct {
        bit [15:0] id;
        bit [11:0] x;
        bit [11:0] y;
        bit        present;
        bit        last;
    } t_blob_rec;

    typedef struct {
        t_op       op;
        bit [11:0] x;
        bit [11:0] y;
        bit [31:0] t;
        bit        empty_chk;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [11:0] i_pos_x;
    logic [11:0] i_pos_y;
    logic [31:0] i_time_ms;
    logic        i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_blob_id;
    logic [11:0] o_blob_x;
    logic [11:0] o_blob_y;
    logic        o_present;
    logic        o_last;

    blob_centroid_tracker dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // tracker mirror
    bit [11:0] r_merge;
    bit [8:0]  r_wgt;
    bit        r_cand_en;
    bit [15:0] r_min_det;
    bit        r_to_en;
    bit [15:0] r_max_und;
    bit        r_low_id;
    bit [15:0] r_max_id;

    int        trk_n, cnd_n;
    bit [11:0] trk_x[SLOTS], trk_y[SLOTS], cnd_x[SLOTS], cnd_y[SLOTS];
    bit [15:0] trk_id[SLOTS];
    bit        trk_pend[SLOTS];
    bit [31:0] trk_seen[SLOTS], cnd_first[SLOTS], cnd_seen[SLOTS];
    bit [15:0] seq_id;

    t_blob_rec expected_blobs[$];
    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 0;

    function automatic int nearest_slot(bit use_cand, bit [11:0] x, bit [11:0] y);
        longint lim, d, bestd, dx, dy;
        int best, n;
        lim = longint'(r_merge) * r_merge;
        best = -1;
        bestd = 0;
        n = use_cand ? cnd_n : trk_n;
        for (int i = 0; i < n; i++) begin
            dx = longint'(x) - (use_cand ? cnd_x[i] : trk_x[i]);
            dy = longint'(y) - (use_cand ? cnd_y[i] : trk_y[i]);
            d = dx * dx + dy * dy;
            if (d < lim && (best < 0 || d < bestd)) begin
                best = i;
                bestd = d;
            end
        end
        return best;
    endfunction

    function automatic void remove_trk(int k);
        for (int i = k; i + 1 < trk_n; i++) begin
            trk_x[i] = trk_x[i+1];
            trk_y[i] = trk_y[i+1];
            trk_id[i] = trk_id[i+1];
            trk_pend[i] = trk_pend[i+1];
            trk_seen[i] = trk_seen[i+1];
        end
        trk_n--;
    endfunction

    function automatic void remove_cnd(int k);
        for (int i = k; i + 1 < cnd_n; i++) begin
            cnd_x[i] = cnd_x[i+1];
            cnd_y[i] = cnd_y[i+1];
            cnd_first[i] = cnd_first[i+1];
            cnd_seen[i] = cnd_seen[i+1];
        end
        cnd_n--;
    endfunction

    function automatic void append_trk(bit [11:0] x, bit [11:0] y, bit [31:0] s);
        if (trk_n >= SLOTS) return;
        trk_x[trk_n] = x;
        trk_y[trk_n] = y;
        trk_seen[trk_n] = s;
        trk_pend[trk_n] = r_low_id;
        trk_id[trk_n] = 0;
        if (!r_low_id) begin
            trk_id[trk_n] = seq_id;
            seq_id++;
        end
        trk_n++;
    endfunction

    function automatic bit id_held(int id);
        for (int i = 0; i < trk_n; i++)
            if (!trk_pend[i] && trk_id[i] == id) return 1;
        return 0;
    endfunction

    function automatic void track_item(t_op op, bit [11:0] x, bit [11:0] y, bit [31:0] t,
                                       ref t_blob_rec res[$]);
        bit [31:0] maxu;
        int m, i, id, w;
        t_blob_rec r;
        maxu = r_to_en ? 32'(r_max_und) : 32'd0;
        res = {};
        if (op == OP_DETECT) begin
            m = nearest_slot(0, x, y);
            if (m >= 0) begin
                w = (r_wgt > 256) ? 256 : r_wgt;
                trk_x[m] = 12'((int'(trk_x[m]) * (256 - w) + int'(x) * w) >> 8);
                trk_y[m] = 12'((int'(trk_y[m]) * (256 - w) + int'(y) * w) >> 8);
                trk_seen[m] = t;
            end else if (r_cand_en) begin
                m = nearest_slot(1, x, y);
                if (m >= 0) begin
                    cnd_x[m] = x;
                    cnd_y[m] = y;
                    cnd_seen[m] = t;
                end else if (cnd_n < SLOTS) begin
                    cnd_x[cnd_n] = x;
                    cnd_y[cnd_n] = y;
                    cnd_first[cnd_n] = t;
                    cnd_seen[cnd_n] = t;
                    cnd_n++;
                end
            end else begin
                append_trk(x, y, t);
            end
            return;
        end
        if (r_cand_en) begin
            i = 0;
            while (i < cnd_n) begin
                if (32'(t - cnd_seen[i]) > maxu) begin
                    remove_cnd(i);
                end else if (32'(cnd_seen[i] - cnd_first[i]) > 32'(r_min_det)) begin
                    r.x = cnd_x[i];
                    r.y = cnd_y[i];
                    maxu = maxu;
                    begin
                        bit [31:0] s;
                        s = cnd_seen[i];
                        remove_cnd(i);
                        append_trk(r.x, r.y, s);
                    end
                end else begin
                    i++;
                end
            end
        end
        i = 0;
        while (i < trk_n) begin
            if (32'(t - trk_seen[i]) > maxu) remove_trk(i);
            else i++;
        end
        if (r_low_id) begin
            i = 0;
            while (i < trk_n) begin
                if (trk_pend[i]) begin
                    id = 0;
                    while (id_held(id)) id++;
                    trk_id[i] = 16'(id);
                    trk_pend[i] = 0;
                    if (id > r_max_id) begin
                        remove_trk(i);
                        continue;
                    end
                end
                i++;
            end
        end
        if (trk_n == 0) begin
            r = '{16'd0, 12'd0, 12'd0, 1'b0, 1'b1};
            res = {res, r};
        end
        for (i = 0; i < trk_n; i++) begin
            r.id = trk_pend[i] ? ID_PENDING_OUT : trk_id[i];
            r.x = trk_x[i];
            r.y = trk_y[i];
            r.present = 1;
            r.last = (i + 1 == trk_n);
            res = {res, r};
        end
    endfunction

    // sender: payload changes only after acceptance
    task automatic send_item(t_op op, bit [11:0] x, bit [11:0] y, bit [31:0] t,
                             bit empty_chk);
        t_blob_rec res[$];
        bit acc;
        while (!no_idle && $urandom_range(99) < 35) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_operation <= op;
        i_pos_x <= x;
        i_pos_y <= y;
        i_time_ms <= t;
        track_item(op, x, y, t, res);
        if (empty_chk) res = '{'{16'd0, 12'd0, 12'd0, 1'b0, 1'b1}};
        expected_blobs = {expected_blobs, res};
        do begin
            @(negedge i_clk);
            acc = !o_stall;
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic settle();
        i_valid <= 0;
        wait (expected_blobs.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(bit [15:0] v[8]);
        for (int a = 0; a < 8; a++) begin
            i_cfg_we <= 1;
            i_cfg_addr <= CFG_ADDR_BITS'(a);
            i_cfg_wdata <= v[a];
            case (t_cfg_addr'(a))
                CFG_MERGE_DIST: r_merge = v[a][11:0];
                CFG_SMOOTH:     r_wgt = v[a][8:0];
                CFG_CAND_EN:    r_cand_en = v[a][0];
                CFG_MIN_DET:    r_min_det = v[a];
                CFG_TIMEOUT_EN: r_to_en = v[a][0];
                CFG_MAX_UNDET:  r_max_und = v[a];
                CFG_LOWEST_ID:  r_low_id = v[a][0];
                CFG_MAX_ID:     r_max_id = v[a];
                default: begin
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // frames of detections around drifting objects, with some noise and odd times
    task automatic random_frames(int n_items);
        int ox[8], oy[8];
        int sent, nd, k, x, y;
        bit [31:0] t;
        t = $urandom;
        foreach (ox[j]) begin
            ox[j] = $urandom_range(4095);
            oy[j] = $urandom_range(4095);
        end
        sent = 0;
        while (sent < n_items) begin
            nd = $urandom_range(6);
            for (int d = 0; d < nd; d++) begin
                if ($urandom_range(99) < 15) begin
                    x = $urandom_range(4095);
                    y = $urandom_range(4095);
                end else begin
                    k = $urandom_range(7);
                    x = ox[k] + $urandom_range(8) - 4;
                    y = oy[k] + $urandom_range(8) - 4;
                    x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
                    y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
                    ox[k] = x;
                    oy[k] = y;
                end
                send_item(OP_DETECT, 12'(x), 12'(y), t, 0);
                sent++;
            end
            send_item(OP_FRAME_END, 12'($urandom), 12'($urandom), t, 0);
            sent++;
            case ($urandom_range(9))
                0:       t = t;
                1:       t = $urandom;
                default: t = t + $urandom_range(1, 300);
            endcase
        end
    endtask

    t_row dir_rows[16] = '{
        '{OP_FRAME_END, 12'd0,    12'd0,    32'd0,          1'b1},
        '{OP_DETECT,    12'd0,    12'd0,    32'd0,          1'b0},
        '{OP_DETECT,    12'd4095, 12'd4095, 32'd0,          1'b0},
        '{OP_DETECT,    12'd4095, 12'd0,    32'd0,          1'b0},
        '{OP_FRAME_END, 12'd0,    12'd0,    32'd100,        1'b1},
        '{OP_DETECT,    12'd0,    12'd0,    32'd600,        1'b0},
        '{OP_DETECT,    12'd4095, 12'd4095, 32'd600,        1'b0},
        '{OP_FRAME_END, 12'd4095, 12'd4095, 32'd700,        1'b0},
        '{OP_DETECT,    12'd3,    12'd4,    32'd800,        1'b0},
        '{OP_DETECT,    12'd4095, 12'd3995, 32'd800,        1'b0},
        '{OP_FRAME_END, 12'd0,    12'd0,    32'd800,        1'b0},
        '{OP_FRAME_END, 12'd0,    12'd0,    32'hFFFF_FFFF,  1'b1},
        '{OP_DETECT,    12'd0,    12'd4095, 32'hFFFF_FFF0,  1'b0},
        '{OP_DETECT,    12'd0,    12'd4095, 32'h0000_01F0,  1'b0},
        '{OP_FRAME_END, 12'd0,    12'd0,    32'h0000_01F0,  1'b0},
        '{OP_FRAME_END, 12'd2048, 12'd2048, 32'h0000_0400,  1'b0}
    };

    // result checker: outputs are stable between rising edges
    always @(negedge i_clk) begin
        t_blob_rec e;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_blobs.size() == 0) begin
                $error("unexpected result id=%0d x=%0d y=%0d", o_blob_id, o_blob_x, o_blob_y);
                errors++;
            end else begin
                e = expected_blobs.pop_front();
                if (o_blob_id !== e.id) begin
                    $error("blob_id expected %0d got %0d", e.id, o_blob_id); errors++;
                end
                if (o_blob_x !== e.x) begin
                    $error("blob_x expected %0d got %0d", e.x, o_blob_x); errors++;
                end
                if (o_blob_y !== e.y) begin
                    $error("blob_y expected %0d got %0d", e.y, o_blob_y); errors++;
                end
                if (o_present !== e.present) begin
                    $error("present expected %0d got %0d", e.present, o_present); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < 35);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 0;
        i_valid <= 0;
        i_operation <= OP_DETECT;
        i_pos_x <= 0;
        i_pos_y <= 0;
        i_time_ms <= 0;
        i_cfg_we <= 0;
        i_cfg_addr <= CFG_MERGE_DIST;
        i_cfg_wdata <= 0;
        r_merge = MERGE_DIST_RST;
        r_wgt = SMOOTH_RST;
        r_cand_en = 1;
        r_min_det = MIN_DET_RST;
        r_to_en = 1;
        r_max_und = MAX_UNDET_RST;
        r_low_id = 0;
        r_max_id = MAX_ID_RST;
        trk_n = 0;
        cnd_n = 0;
        seq_id = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].op, dir_rows[r].x, dir_rows[r].y, dir_rows[r].t,
                      dir_rows[r].empty_chk);
        random_frames(40);
        settle();

        // lowest ids with a tight id ceiling
        write_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0});
        random_frames(40);
        settle();

        no_idle = 1;
        write_regs('{16'd4095, 16'd256, 16'd1, 16'd65535, 16'd1, 16'd65535, 16'd0,
                     16'd65535});
        random_frames(35);
        settle();
        no_idle = 0;

        write_regs('{16'd300, 16'd100, 16'd1, 16'd50, 16'd1, 16'd200, 16'd1, 16'd5});
        random_frames(45);
        settle();

        // weight above one in lowest id mode, then sequential ids with timeouts off
        write_regs('{16'd2000, 16'd511, 16'd0, 16'd500, 16'd1, 16'd400, 16'd1, 16'd9999});
        random_frames(10);
        settle();
        write_regs('{16'd2000, 16'd300, 16'd0, 16'd500, 16'd0, 16'd400, 16'd0, 16'd9999});
        random_frames(30);
        settle();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
